/* rtl/core/brpg_pkg.sv */
package brpg_pkg;

    localparam logic [11:0] PANEL_W_RST = 12'd240;
    localparam logic [11:0] PANEL_H_RST = 12'd320;

    localparam logic OP_RECT = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [2:0] {
        KIND_WINDOW = 3'd0,
        KIND_PIXEL  = 3'd1,
        KIND_REJECT = 3'd2,
        KIND_EMPTY  = 3'd3,
        KIND_IDLE   = 3'd4,
        KIND_BUSY   = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        REG_PANEL_W = 2'd0,
        REG_PANEL_H = 2'd1,
        REG_COL_OFF = 2'd2,
        REG_ROW_OFF = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [11:0] panel_w;
        logic [11:0] panel_h;
        logic [15:0] col_off;
        logic [15:0] row_off;
    } t_cfg;

    typedef struct packed {
        logic        op;
        logic [15:0] rect_x;
        logic [15:0] rect_y;
        logic [15:0] rect_w;
        logic [15:0] rect_h;
        logic [15:0] fill_rgb;
        logic [15:0] edge_rgb;
        logic [7:0]  thick;
    } t_req;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] col_first;
        logic [15:0] col_final;
        logic [15:0] row_first;
        logic [15:0] row_final;
        logic [15:0] pixel_rgb;
        logic        last_pixel;
    } t_res;

endpackage

/* rtl/core/brpg_cfg.sv */
module brpg_cfg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready,
    output brpg_pkg::t_cfg o_cfg
);
    import brpg_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.panel_w <= PANEL_W_RST;
            r_cfg.panel_h <= PANEL_H_RST;
            r_cfg.col_off <= '0;
            r_cfg.row_off <= '0;
        end else if (wr_en) begin
            case (idx)
                REG_PANEL_W: r_cfg.panel_w <= pwdata[11:0];
                REG_PANEL_H: r_cfg.panel_h <= pwdata[11:0];
                REG_COL_OFF: r_cfg.col_off <= pwdata[15:0];
                REG_ROW_OFF: r_cfg.row_off <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_PANEL_W: prdata = {20'd0, r_cfg.panel_w};
            REG_PANEL_H: prdata = {20'd0, r_cfg.panel_h};
            REG_COL_OFF: prdata = {16'd0, r_cfg.col_off};
            REG_ROW_OFF: prdata = {16'd0, r_cfg.row_off};
            default:     prdata = '0;
        endcase
    end

endmodule

/* rtl/core/brpg_in_stage.sv */
module brpg_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  brpg_pkg::t_req i_req,
    input  logic           i_adv,
    output logic           o_ready,
    output logic           o_valid,
    output brpg_pkg::t_req o_req
);
    import brpg_pkg::*;

    logic r_valid;
    t_req r_req;

    assign o_ready = !r_valid || i_adv;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req <= i_req;
        end
    end

endmodule

/* rtl/core/brpg_engine.sv */
module brpg_engine (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  brpg_pkg::t_cfg i_cfg,
    input  logic           i_valid,
    input  brpg_pkg::t_req i_req,
    input  logic           i_out_ready,
    output logic           o_adv,
    output logic           o_valid,
    output brpg_pkg::t_res o_res
);
    import brpg_pkg::*;

    logic        r_busy;
    logic [11:0] r_clip_w;
    logic [11:0] r_clip_h;
    logic [7:0]  r_thick;
    logic [15:0] r_inner;
    logic [15:0] r_outer;
    logic [11:0] r_col;
    logic [11:0] r_row;
    logic        r_out_valid;
    t_res        r_res;

    logic        n_busy;
    logic [11:0] n_clip_w;
    logic [11:0] n_clip_h;
    logic [7:0]  n_thick;
    logic [11:0] n_col;
    logic [11:0] n_row;
    t_res        n_res;

    logic        step;
    logic [16:0] sum_x;
    logic [16:0] sum_y;
    logic [11:0] cw;
    logic [11:0] ch;
    logic [10:0] lim;
    logic        border;
    logic        col_end;
    logic        row_end;

    assign o_adv   = !r_out_valid || i_out_ready;
    assign step    = i_valid && o_adv;
    assign o_valid = r_out_valid;
    assign o_res   = r_res;

    // clipped size; x < panel width holds wherever these are used
    assign sum_x = {1'b0, i_req.rect_x} + {1'b0, i_req.rect_w};
    assign sum_y = {1'b0, i_req.rect_y} + {1'b0, i_req.rect_h};
    assign cw    = (sum_x > {5'd0, i_cfg.panel_w}) ? i_cfg.panel_w - i_req.rect_x[11:0]
                                                  : i_req.rect_w[11:0];
    assign ch    = (sum_y > {5'd0, i_cfg.panel_h}) ? i_cfg.panel_h - i_req.rect_y[11:0]
                                                  : i_req.rect_h[11:0];
    assign lim   = (ch[11:1] < cw[11:1]) ? ch[11:1] : cw[11:1];

    assign border = (r_thick != 8'd0) &&
                    (r_row < {4'd0, r_thick} || r_row >= r_clip_h - {4'd0, r_thick} ||
                     r_col < {4'd0, r_thick} || r_col >= r_clip_w - {4'd0, r_thick});
    assign col_end = ({1'b0, r_col} + 13'd1) >= {1'b0, r_clip_w};
    assign row_end = ({1'b0, r_row} + 13'd1) >= {1'b0, r_clip_h};

    always_comb begin
        n_busy   = r_busy;
        n_clip_w = r_clip_w;
        n_clip_h = r_clip_h;
        n_thick  = r_thick;
        n_col    = r_col;
        n_row    = r_row;
        n_res    = '0;
        if (i_req.op == OP_RECT) begin
            if (r_busy) begin
                n_res.kind = KIND_BUSY;
            end else if (i_req.rect_x >= {4'd0, i_cfg.panel_w} ||
                         i_req.rect_y >= {4'd0, i_cfg.panel_h}) begin
                n_res.kind = KIND_REJECT;
            end else if (i_req.rect_w == 16'd0 || i_req.rect_h == 16'd0) begin
                n_res.kind = KIND_EMPTY;
            end else begin
                n_busy   = 1'b1;
                n_clip_w = cw;
                n_clip_h = ch;
                n_col    = '0;
                n_row    = '0;
                if (i_req.thick == 8'd0 || i_req.fill_rgb == i_req.edge_rgb) begin
                    n_thick = '0;
                end else if ({3'd0, i_req.thick} > lim) begin
                    n_thick = lim[7:0];
                end else begin
                    n_thick = i_req.thick;
                end
                n_res.kind      = KIND_WINDOW;
                n_res.col_first = i_req.rect_x + i_cfg.col_off;
                n_res.col_final = i_req.rect_x + {4'd0, cw} - 16'd1 + i_cfg.col_off;
                n_res.row_first = i_req.rect_y + i_cfg.row_off;
                n_res.row_final = i_req.rect_y + {4'd0, ch} - 16'd1 + i_cfg.row_off;
            end
        end else if (!r_busy) begin
            n_res.kind = KIND_IDLE;
        end else begin
            n_res.kind      = KIND_PIXEL;
            n_res.pixel_rgb = border ? r_outer : r_inner;
            if (col_end) begin
                n_col = '0;
                if (row_end) begin
                    n_res.last_pixel = 1'b1;
                    n_row  = '0;
                    n_busy = 1'b0;
                end else begin
                    n_row = r_row + 12'd1;
                end
            end else begin
                n_col = r_col + 12'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_adv) begin
                r_out_valid <= i_valid;
            end
            if (step) begin
                r_busy <= n_busy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_clip_w <= n_clip_w;
            r_clip_h <= n_clip_h;
            r_thick  <= n_thick;
            r_col    <= n_col;
            r_row    <= n_row;
            r_res    <= n_res;
            if (i_req.op == OP_RECT && !r_busy) begin
                r_inner <= i_req.fill_rgb;
                r_outer <= i_req.edge_rgb;
            end
        end
    end

endmodule

/* rtl/core/bordered_rect_pixel_generator.sv */
// A request passes through the input register, then the result register, before
// its result is offered on the output.
// Throughput: one request per cycle, commands and pixel ticks alike; the stages
// advance together whenever the result register is empty or being taken.
// Reset (synchronous, active low) empties both stages, clears the busy flag and
// loads the panel size 240 x 320 with zero offsets.
module bordered_rect_pixel_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [15:0] i_rect_x,
    input  logic [15:0] i_rect_y,
    input  logic [15:0] i_rect_w,
    input  logic [15:0] i_rect_h,
    input  logic [15:0] i_fill_rgb,
    input  logic [15:0] i_edge_rgb,
    input  logic [7:0]  i_edge_thickness,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_kind,
    output logic [15:0] o_col_first,
    output logic [15:0] o_col_final,
    output logic [15:0] o_row_first,
    output logic [15:0] o_row_final,
    output logic [15:0] o_pixel_rgb,
    output logic        o_last_pixel,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import brpg_pkg::*;

    t_cfg cfg;
    t_req in_req;
    t_req st_req;
    t_res res;
    logic st_valid;
    logic adv;

    assign in_req.op       = i_op;
    assign in_req.rect_x   = i_rect_x;
    assign in_req.rect_y   = i_rect_y;
    assign in_req.rect_w   = i_rect_w;
    assign in_req.rect_h   = i_rect_h;
    assign in_req.fill_rgb = i_fill_rgb;
    assign in_req.edge_rgb = i_edge_rgb;
    assign in_req.thick    = i_edge_thickness;

    brpg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    brpg_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_req   (in_req),
        .i_adv   (adv),
        .o_ready (o_ready),
        .o_valid (st_valid),
        .o_req   (st_req)
    );

    brpg_engine u_eng (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (st_valid),
        .i_req       (st_req),
        .i_out_ready (i_ready),
        .o_adv       (adv),
        .o_valid     (o_valid),
        .o_res       (res)
    );

    assign o_kind       = res.kind;
    assign o_col_first  = res.col_first;
    assign o_col_final  = res.col_final;
    assign o_row_first  = res.row_first;
    assign o_row_final  = res.row_final;
    assign o_pixel_rgb  = res.pixel_rgb;
    assign o_last_pixel = res.last_pixel;

`ifndef SYNTHESIS
    a_last_is_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_pixel |-> o_kind == KIND_PIXEL)
        else $error("last marker on a non-pixel result");

    a_window_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != KIND_WINDOW |->
            o_col_first == 16'd0 && o_col_final == 16'd0 &&
            o_row_first == 16'd0 && o_row_final == 16'd0)
        else $error("window fields set outside a window result");

    a_pixel_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != KIND_PIXEL |-> o_pixel_rgb == 16'd0)
        else $error("pixel field set outside a pixel result");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty result register");
`endif

endmodule

/* sim/brpg_checker.sv */
module brpg_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic        i_op,
    input  logic [15:0] i_rect_x,
    input  logic [15:0] i_rect_y,
    input  logic [15:0] i_rect_w,
    input  logic [15:0] i_rect_h,
    input  logic [15:0] i_fill_rgb,
    input  logic [15:0] i_edge_rgb,
    input  logic [7:0]  i_edge_thickness,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [2:0]  o_kind,
    input  logic [15:0] o_col_first,
    input  logic [15:0] o_col_final,
    input  logic [15:0] o_row_first,
    input  logic [15:0] o_row_final,
    input  logic [15:0] o_pixel_rgb,
    input  logic        o_last_pixel,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import brpg_pkg::*;

    logic [11:0] cfg_pw;
    logic [11:0] cfg_ph;
    logic [15:0] cfg_col_off;
    logic [15:0] cfg_row_off;

    logic        busy_q;
    logic [15:0] clip_w;
    logic [15:0] clip_h;
    logic [15:0] thick_q;
    logic [15:0] inner_rgb;
    logic [15:0] outer_rgb;
    logic [15:0] col_pos;
    logic [15:0] row_pos;

    t_res owed_results[$];

    // advances the raster state for one request and returns its response
    function automatic t_res rasterize(input t_req r);
        t_res res;
        int   x;
        int   y;
        int   w;
        int   h;
        int   t;
        int   lim;
        logic on_border;
        res = '0;
        x = r.rect_x;
        y = r.rect_y;
        w = r.rect_w;
        h = r.rect_h;
        if (r.op == OP_RECT) begin
            if (busy_q) begin
                res.kind = KIND_BUSY;
            end else if (x >= int'(cfg_pw) || y >= int'(cfg_ph)) begin
                res.kind = KIND_REJECT;
            end else if (w == 0 || h == 0) begin
                res.kind = KIND_EMPTY;
            end else begin
                if (x + w > int'(cfg_pw)) w = int'(cfg_pw) - x;
                if (y + h > int'(cfg_ph)) h = int'(cfg_ph) - y;
                t = (r.fill_rgb == r.edge_rgb) ? 0 : int'(r.thick);
                lim = (w / 2 < h / 2) ? w / 2 : h / 2;
                if (t > lim) t = lim;
                clip_w    = 16'(w);
                clip_h    = 16'(h);
                thick_q   = 16'(t);
                inner_rgb = r.fill_rgb;
                outer_rgb = r.edge_rgb;
                col_pos   = '0;
                row_pos   = '0;
                busy_q    = 1'b1;
                res.kind      = KIND_WINDOW;
                res.col_first = 16'(x + int'(cfg_col_off));
                res.col_final = 16'(x + w - 1 + int'(cfg_col_off));
                res.row_first = 16'(y + int'(cfg_row_off));
                res.row_final = 16'(y + h - 1 + int'(cfg_row_off));
            end
        end else if (!busy_q) begin
            res.kind = KIND_IDLE;
        end else begin
            on_border = thick_q != 0 &&
                (row_pos < thick_q || int'(row_pos) >= int'(clip_h) - int'(thick_q) ||
                 col_pos < thick_q || int'(col_pos) >= int'(clip_w) - int'(thick_q));
            res.kind      = KIND_PIXEL;
            res.pixel_rgb = on_border ? outer_rgb : inner_rgb;
            if (int'(col_pos) + 1 >= int'(clip_w)) begin
                col_pos = '0;
                if (int'(row_pos) + 1 >= int'(clip_h)) begin
                    res.last_pixel = 1'b1;
                    row_pos = '0;
                    busy_q  = 1'b0;
                end else begin
                    row_pos = row_pos + 16'd1;
                end
            end else begin
                col_pos = col_pos + 16'd1;
            end
        end
        return res;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_req req;
        t_res want;
        if (!i_rst_n) begin
            cfg_pw      = PANEL_W_RST;
            cfg_ph      = PANEL_H_RST;
            cfg_col_off = '0;
            cfg_row_off = '0;
            busy_q      = 1'b0;
            clip_w      = '0;
            clip_h      = '0;
            thick_q     = '0;
            inner_rgb   = '0;
            outer_rgb   = '0;
            col_pos     = '0;
            row_pos     = '0;
            owed_results.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[3:2]))
                    REG_PANEL_W: cfg_pw      = pwdata[11:0];
                    REG_PANEL_H: cfg_ph      = pwdata[11:0];
                    REG_COL_OFF: cfg_col_off = pwdata[15:0];
                    REG_ROW_OFF: cfg_row_off = pwdata[15:0];
                    default: ;
                endcase
            end
            if (o_valid && i_ready) begin
                if (owed_results.size() == 0) begin
                    $display("%0t: response with no request outstanding, kind %0d",
                             $time, o_kind);
                    o_errors++;
                end else begin
                    want = owed_results.pop_front();
                    check_field("kind", want.kind, o_kind);
                    check_field("col_first", want.col_first, o_col_first);
                    check_field("col_final", want.col_final, o_col_final);
                    check_field("row_first", want.row_first, o_row_first);
                    check_field("row_final", want.row_final, o_row_final);
                    check_field("pixel_rgb", want.pixel_rgb, o_pixel_rgb);
                    check_field("last_pixel", want.last_pixel, o_last_pixel);
                end
            end
            if (i_valid && o_ready) begin
                req.op       = i_op;
                req.rect_x   = i_rect_x;
                req.rect_y   = i_rect_y;
                req.rect_w   = i_rect_w;
                req.rect_h   = i_rect_h;
                req.fill_rgb = i_fill_rgb;
                req.edge_rgb = i_edge_rgb;
                req.thick    = i_edge_thickness;
                owed_results.push_back(rasterize(req));
            end
        end
        o_pending = owed_results.size();
    end

endmodule

/* sim/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import brpg_pkg::*;

    localparam int STALL_LIMIT     = 2000;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int NUM_PHASES      = 8;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_op;
    logic [15:0] i_rect_x;
    logic [15:0] i_rect_y;
    logic [15:0] i_rect_w;
    logic [15:0] i_rect_h;
    logic [15:0] i_fill_rgb;
    logic [15:0] i_edge_rgb;
    logic [7:0]  i_edge_thickness;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_kind;
    logic [15:0] o_col_first;
    logic [15:0] o_col_final;
    logic [15:0] o_row_first;
    logic [15:0] o_row_final;
    logic [15:0] o_pixel_rgb;
    logic        o_last_pixel;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int err_cnt;
    int pending_cnt;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int items_sent    = 0;
    int pixels_left   = 0;
    int stall_cycles  = 0;
    int pw_now        = PANEL_W_RST;
    int ph_now        = PANEL_H_RST;

    bordered_rect_pixel_generator u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_op             (i_op),
        .i_rect_x         (i_rect_x),
        .i_rect_y         (i_rect_y),
        .i_rect_w         (i_rect_w),
        .i_rect_h         (i_rect_h),
        .i_fill_rgb       (i_fill_rgb),
        .i_edge_rgb       (i_edge_rgb),
        .i_edge_thickness (i_edge_thickness),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_kind           (o_kind),
        .o_col_first      (o_col_first),
        .o_col_final      (o_col_final),
        .o_row_first      (o_row_first),
        .o_row_final      (o_row_final),
        .o_pixel_rgb      (o_pixel_rgb),
        .o_last_pixel     (o_last_pixel),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    brpg_checker u_chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_op             (i_op),
        .i_rect_x         (i_rect_x),
        .i_rect_y         (i_rect_y),
        .i_rect_w         (i_rect_w),
        .i_rect_h         (i_rect_h),
        .i_fill_rgb       (i_fill_rgb),
        .i_edge_rgb       (i_edge_rgb),
        .i_edge_thickness (i_edge_thickness),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_kind           (o_kind),
        .o_col_first      (o_col_first),
        .o_col_final      (o_col_final),
        .o_row_first      (o_row_first),
        .o_row_final      (o_row_final),
        .o_pixel_rgb      (o_pixel_rgb),
        .o_last_pixel     (o_last_pixel),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .pready           (pready),
        .o_errors         (err_cnt),
        .o_pending        (pending_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_ready = ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_cycles <= 0;
        end else if ((i_valid && o_ready) || (o_valid && i_ready) ||
                     (psel && penable && pwrite && pready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic t_req rand_tick();
        t_req r;
        r.op       = OP_TICK;
        r.rect_x   = 16'($urandom);
        r.rect_y   = 16'($urandom);
        r.rect_w   = 16'($urandom);
        r.rect_h   = 16'($urandom);
        r.fill_rgb = 16'($urandom);
        r.edge_rgb = 16'($urandom);
        r.thick    = 8'($urandom);
        return r;
    endfunction

    function automatic t_req make_rect(input int x, input int y, input int w, input int h,
                                       input int fill_c, input int border_c, input int t);
        t_req r;
        r.op       = OP_RECT;
        r.rect_x   = 16'(x);
        r.rect_y   = 16'(y);
        r.rect_w   = 16'(w);
        r.rect_h   = 16'(h);
        r.fill_rgb = 16'(fill_c);
        r.edge_rgb = 16'(border_c);
        r.thick    = 8'(t);
        return r;
    endfunction

    function automatic int pick_origin(input int lim);
        if ($urandom_range(0, 1) == 0) return $urandom_range(0, lim - 1);
        return lim - 1 - $urandom_range(0, (lim > 4) ? 3 : lim - 1);
    endfunction

    // large sizes only where the clip keeps the pixel count small
    function automatic int pick_size(input int room);
        if (room <= 8 && $urandom_range(0, 2) == 0) return $urandom_range(room, 65535);
        return $urandom_range(1, 8);
    endfunction

    task automatic send(input t_req r);
        int cw;
        int ch;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_op             = r.op;
        i_rect_x         = r.rect_x;
        i_rect_y         = r.rect_y;
        i_rect_w         = r.rect_w;
        i_rect_h         = r.rect_h;
        i_fill_rgb       = r.fill_rgb;
        i_edge_rgb       = r.edge_rgb;
        i_edge_thickness = r.thick;
        i_valid          = 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items_sent++;
        if (r.op == OP_TICK) begin
            if (pixels_left > 0) pixels_left--;
        end else if (pixels_left == 0 && r.rect_x < pw_now && r.rect_y < ph_now &&
                     r.rect_w != 0 && r.rect_h != 0) begin
            cw = (r.rect_x + r.rect_w > pw_now) ? pw_now - r.rect_x : r.rect_w;
            ch = (r.rect_y + r.rect_h > ph_now) ? ph_now - r.rect_y : r.rect_h;
            pixels_left = cw * ch;
        end
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid = 1'b0;
        while (pending_cnt != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input int value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = 32'(value);
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_panel(input int pw, input int ph, input int col_off, input int row_off);
        wait_drained();
        write_reg(REG_PANEL_W, pw);
        write_reg(REG_PANEL_H, ph);
        write_reg(REG_COL_OFF, col_off);
        write_reg(REG_ROW_OFF, row_off);
        pw_now = pw;
        ph_now = ph;
    endtask

    task automatic draw_rect();
        int   x;
        int   y;
        int   sel;
        int   t;
        int   fill_c;
        int   border_c;
        t_req r;
        while (pixels_left > 0) send(rand_tick());
        x = pick_origin(pw_now);
        y = pick_origin(ph_now);
        fill_c   = $urandom_range(0, 65535);
        border_c = ($urandom_range(0, 99) < 15) ? fill_c : $urandom_range(0, 65535);
        sel = $urandom_range(0, 9);
        t = (sel < 2) ? 0 : (sel == 2) ? 255 : (sel < 8) ? $urandom_range(1, 4)
                                                         : $urandom_range(0, 255);
        send(make_rect(x, y, pick_size(pw_now - x), pick_size(ph_now - y),
                       fill_c, border_c, t));
        while (pixels_left > 0) begin
            if ($urandom_range(0, 99) < 4) begin
                r = rand_tick();
                r.op = OP_RECT;
                send(r);
            end else begin
                send(rand_tick());
            end
        end
        if ($urandom_range(0, 99) < 10) send(rand_tick());
    endtask

    task automatic random_step();
        int   sel;
        t_req r;
        sel = $urandom_range(0, 99);
        r = rand_tick();
        r.op = OP_RECT;
        if (sel < 70) begin
            draw_rect();
        end else if (sel < 78) begin
            if ($urandom_range(0, 1) == 0) r.rect_x = 16'($urandom_range(pw_now, 65535));
            else r.rect_y = 16'($urandom_range(ph_now, 65535));
            send(r);
        end else if (sel < 86) begin
            r.rect_x = 16'($urandom_range(0, pw_now - 1));
            r.rect_y = 16'($urandom_range(0, ph_now - 1));
            if ($urandom_range(0, 1) == 0) r.rect_w = '0;
            else r.rect_h = '0;
            send(r);
        end else if (sel < 94) begin
            send(rand_tick());
        end else begin
            // rectangle abandoned after a few pixels
            send(make_rect($urandom_range(0, pw_now - 1), $urandom_range(0, ph_now - 1),
                           $urandom_range(1, 8), $urandom_range(1, 8),
                           $urandom_range(0, 65535), $urandom_range(0, 65535),
                           $urandom_range(0, 255)));
            repeat ($urandom_range(0, 2)) send(rand_tick());
        end
    endtask

    initial begin
        int ph;
        int phase_end;
        bit paused;
        paused           = 1'b0;
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_op             = OP_RECT;
        i_rect_x         = '0;
        i_rect_y         = '0;
        i_rect_w         = '0;
        i_rect_h         = '0;
        i_fill_rgb       = '0;
        i_edge_rgb       = '0;
        i_edge_thickness = '0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        send(rand_tick());
        send(make_rect(240, 0, 5, 5, 16'h0001, 16'h0002, 1));
        send(make_rect(0, 320, 5, 5, 16'h0001, 16'h0002, 1));
        send(make_rect(65535, 65535, 65535, 65535, 16'hFFFF, 16'h0000, 255));
        send(make_rect(10, 10, 0, 7, 16'h1111, 16'h2222, 1));
        send(make_rect(10, 10, 7, 0, 16'h1111, 16'h2222, 1));
        send(make_rect(0, 0, 2, 2, 16'h0000, 16'hFFFF, 0));
        send(make_rect(1, 1, 1, 1, 16'h3333, 16'h4444, 1));
        while (pixels_left > 0) send(rand_tick());
        send(make_rect(236, 318, 65535, 65535, 16'hF800, 16'h07E0, 255));
        while (pixels_left > 0) send(rand_tick());
        send(make_rect(239, 319, 1, 1, 16'h1234, 16'h1234, 9));
        while (pixels_left > 0) send(rand_tick());
        send(make_rect(5, 5, 1, 3, 16'hAAAA, 16'h5555, 3));
        while (pixels_left > 0) send(rand_tick());

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: ;
                1: set_panel(4095, 4095, 65535, 65535);
                2: set_panel(1, 1, 0, 0);
                3: set_panel($urandom_range(1, 32), $urandom_range(1, 32),
                             $urandom_range(0, 65535), $urandom_range(0, 65535));
                5: set_panel(4095, 1, $urandom_range(65000, 65535), $urandom_range(0, 65535));
                6: set_panel(1, 4095, $urandom_range(0, 65535), $urandom_range(65000, 65535));
                default: set_panel($urandom_range(1, 4095), $urandom_range(1, 4095),
                                   $urandom_range(0, 65535), $urandom_range(0, 65535));
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 66; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 66; end
                default: begin send_idle_pct = 31; stall_pct = 31; end
            endcase
            phase_end = items_sent + ITEMS_PER_PHASE;
            while (items_sent < phase_end) begin
                if (ph == 0 && !paused && items_sent >= phase_end - ITEMS_PER_PHASE / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
                random_step();
            end
        end

        wait_drained();
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
